### hw/rtl/sha512_stream_hasher_defines.svh
// assertion macros for the sha-512 stream hasher
`ifndef SHA512_STREAM_HASHER_DEFINES_SVH
`define SHA512_STREAM_HASHER_DEFINES_SVH

// same-cycle implication
`define SHA_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication
`define SHA_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

### hw/rtl/sha512_pkg.sv
// shared types, constants and functions for the sha-512 stream hasher
package sha512_pkg;

    typedef struct packed {
        logic       put_byte;
        logic       pad;
        logic       clr;
        logic       len;
        logic       load;
        logic       round;
        logic       add;
        logic       reset_msg;
        logic       emit_load;
        logic [2:0] emit_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic pos_full;
        logic used_ge112;
        logic round_last;
    } dp_status_t;

    localparam logic [63:0] IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] KTAB [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [6:0] BLOCK_LAST_POS = 7'h7F;
    localparam logic [6:0] PAD_SPLIT_POS = 7'd112;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] big_s0(input logic [63:0] x);
        big_s0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic logic [63:0] big_s1(input logic [63:0] x);
        big_s1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic logic [63:0] small_s0(input logic [63:0] x);
        small_s0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] small_s1(input logic [63:0] x);
        small_s1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

    // byte lanes before b kept, lane b set, lanes after cleared
    function automatic logic [63:0] put_lane(input logic [63:0] w, input logic [2:0] b,
                                             input logic [7:0] v);
        logic [63:0] r;
        r = '0;
        for (int j = 0; j < 8; j++)
        begin
            if (3'(j) < b)
                r[63 - 8*j -: 8] = w[63 - 8*j -: 8];
            else if (3'(j) == b)
                r[63 - 8*j -: 8] = v;
        end
        put_lane = r;
    endfunction

endpackage

### hw/rtl/sha512_dp.sv
// sha-512 datapath: block window, round registers, hash words, byte count
module sha512_dp #(
    parameter int LENGTH_COUNT_BITS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha512_pkg::dp_cmd_t    cmd,
    input  logic [7:0]             data_byte,
    output sha512_pkg::dp_status_t status,
    output logic [63:0]            digest_word
);
    import sha512_pkg::*;

    logic [63:0] w_reg [16];
    logic [63:0] r_reg [8];
    logic [63:0] h_reg [8];
    logic [LENGTH_COUNT_BITS-1:0] count_reg;
    logic [6:0] rnd_reg;
    logic [63:0] dw_reg;

    logic [3:0] wpos;
    logic [2:0] bpos;
    logic [127:0] bitlen;
    logic [63:0] w_new, t1, t2, ch, maj;

    assign wpos = count_reg[6:3];
    assign bpos = count_reg[2:0];
    assign bitlen = 128'(count_reg) << 3;

    assign w_new = small_s1(w_reg[14]) + w_reg[9] + small_s0(w_reg[1]) + w_reg[0];
    assign ch = r_reg[6] ^ (r_reg[4] & (r_reg[5] ^ r_reg[6]));
    assign maj = (r_reg[0] & r_reg[1]) | (r_reg[2] & (r_reg[0] | r_reg[1]));
    assign t1 = r_reg[7] + big_s1(r_reg[4]) + ch + KTAB[rnd_reg] + w_reg[0];
    assign t2 = big_s0(r_reg[0]) + maj;

    always_ff @(posedge clk)
    begin
        if (cmd.put_byte)
        begin
            for (int i = 0; i < 16; i++)
                if (4'(i) == wpos)
                    w_reg[i] <= put_lane(w_reg[i], bpos, data_byte);
        end
        else if (cmd.pad)
        begin
            for (int i = 0; i < 16; i++)
            begin
                if (4'(i) == wpos)
                    w_reg[i] <= put_lane(w_reg[i], bpos, PAD_BYTE);
                else if (4'(i) > wpos)
                    w_reg[i] <= '0;
            end
        end
        else if (cmd.clr)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= '0;
        end
        else if (cmd.len)
        begin
            w_reg[14] <= bitlen[127:64];
            w_reg[15] <= bitlen[63:0];
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 8; i++)
                r_reg[i] <= h_reg[i];
        end
        else if (cmd.round)
        begin
            r_reg[7] <= r_reg[6];
            r_reg[6] <= r_reg[5];
            r_reg[5] <= r_reg[4];
            r_reg[4] <= r_reg[3] + t1;
            r_reg[3] <= r_reg[2];
            r_reg[2] <= r_reg[1];
            r_reg[1] <= r_reg[0];
            r_reg[0] <= t1 + t2;
        end
        if (cmd.emit_load)
            dw_reg <= h_reg[cmd.emit_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= IV[i];
            count_reg <= '0;
            rnd_reg <= '0;
        end
        else
        begin
            if (cmd.add)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + r_reg[i];
            end
            else if (cmd.reset_msg)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= IV[i];
            end
            if (cmd.put_byte)
                count_reg <= count_reg + 1'b1;
            else if (cmd.reset_msg)
                count_reg <= '0;
            if (cmd.load)
                rnd_reg <= '0;
            else if (cmd.round)
                rnd_reg <= rnd_reg + 7'd1;
        end
    end

    assign status.pos_full = (count_reg[6:0] == BLOCK_LAST_POS);
    assign status.used_ge112 = (count_reg[6:0] >= PAD_SPLIT_POS);
    assign status.round_last = (rnd_reg == LAST_ROUND);
    assign digest_word = dw_reg;

endmodule

### hw/rtl/sha512_ctrl.sv
// sha-512 controller state machine and output handshake
module sha512_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   byte_present,
    input  logic                   end_of_message,
    input  logic                   out_stall,
    input  sha512_pkg::dp_status_t status,
    output sha512_pkg::dp_cmd_t    cmd,
    output logic                   in_stall,
    output logic                   out_valid,
    output logic [2:0]             word_index,
    output logic                   last_word
);
    import sha512_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LOAD  = 9'b000000010,
        S_ROUND = 9'b000000100,
        S_ADD   = 9'b000001000,
        S_PAD   = 9'b000010000,
        S_CLR   = 9'b000100000,
        S_LEN   = 9'b001000000,
        S_SHOW  = 9'b010000000,
        S_EMIT  = 9'b100000000
    } state_t;

    typedef enum logic [1:0] {
        PH_DATA  = 2'd0,
        PH_PAD1  = 2'd1,
        PH_FINAL = 2'd2
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic end_pend_reg, end_pend_next;
    logic out_valid_reg, out_valid_next;
    logic [2:0] idx_reg, idx_next;
    logic in_acc, out_acc;

    assign in_acc = in_valid && (state_reg == S_IDLE);
    assign out_acc = out_valid_reg && !out_stall;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        end_pend_next = end_pend_reg;
        out_valid_next = out_valid_reg;
        idx_next = idx_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    cmd.put_byte = byte_present;
                    if (byte_present && status.pos_full)
                    begin
                        state_next = S_LOAD;
                        phase_next = PH_DATA;
                        end_pend_next = end_of_message;
                    end
                    else if (end_of_message)
                        state_next = S_PAD;
                end
            end
            S_LOAD:
            begin
                cmd.load = 1'b1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                if (status.round_last)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add = 1'b1;
                case (phase_reg)
                    PH_DATA:  state_next = end_pend_reg ? S_PAD : S_IDLE;
                    PH_PAD1:  state_next = S_CLR;
                    PH_FINAL: state_next = S_SHOW;
                    default:  state_next = S_IDLE;
                endcase
            end
            S_PAD:
            begin
                cmd.pad = 1'b1;
                if (status.used_ge112)
                begin
                    phase_next = PH_PAD1;
                    state_next = S_LOAD;
                end
                else
                    state_next = S_LEN;
            end
            S_CLR:
            begin
                cmd.clr = 1'b1;
                state_next = S_LEN;
            end
            S_LEN:
            begin
                cmd.len = 1'b1;
                phase_next = PH_FINAL;
                state_next = S_LOAD;
            end
            S_SHOW:
            begin
                cmd.emit_load = 1'b1;
                cmd.emit_idx = 3'd0;
                idx_next = 3'd0;
                out_valid_next = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_acc)
                begin
                    if (idx_reg == 3'd7)
                    begin
                        out_valid_next = 1'b0;
                        cmd.reset_msg = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                        cmd.emit_load = 1'b1;
                        cmd.emit_idx = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_DATA;
            end_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            end_pend_reg <= end_pend_next;
            out_valid_reg <= out_valid_next;
            idx_reg <= idx_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign word_index = idx_reg;
    assign last_word = (idx_reg == 3'd7);

endmodule

### hw/rtl/sha512_stream_hasher.sv
// an item that does not complete a block is absorbed directly in the idle state; a full block
// then runs one load, 80 rounds of the single round unit and one add into the hash words
// end of message: a pad step, then a length step and one compression, or a compression,
// a clear and a length step and a second one, then a show step before 8 digest items
// throughput: one item per cycle while a block fills; input stalls during compression and emit
// async active-low reset loads the initial hash values and clears count and control
module sha512_stream_hasher #(
    parameter int LENGTH_COUNT_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sha512_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    sha512_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_stall      (out_stall),
        .status         (status),
        .cmd            (cmd),
        .in_stall       (in_stall),
        .out_valid      (out_valid),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    sha512_dp #(
        .LENGTH_COUNT_BITS (LENGTH_COUNT_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .status      (status),
        .digest_word (digest_word)
    );

endmodule

### hw/rtl/sha512_checker.sv
// port-level assertion checker for the sha-512 stream hasher, with its bind
`include "sha512_stream_hasher_defines.svh"

module sha512_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word
);
    `SHA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(digest_word) && $stable(word_index))
    `SHA_ASSERT_IMPLY(a_no_input_during_emit, clk, rst_n, out_valid, in_stall)
    `SHA_ASSERT_NEXT(a_index_steps, clk, rst_n, out_valid && !out_stall && !last_word, out_valid && (word_index == 3'($past(word_index) + 3'd1)))
    `SHA_ASSERT_IMPLY(a_last_is_seven, clk, rst_n, out_valid, last_word == (word_index == 3'd7))
    `SHA_ASSERT_NEXT(a_done_after_last, clk, rst_n, out_valid && !out_stall && last_word, !out_valid)
endmodule

bind sha512_stream_hasher sha512_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
);

### tb/sv/sha512_stream_hasher_checker.sv
// checker for the sha-512 stream hasher: predicts digests from accepted items and compares
`timescale 1ns / 1ps
module sha512_stream_hasher_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        last_word,
    output int          fail_count,
    output int          words_pending
);
    import sha512_pkg::*;

    typedef struct {
        logic [63:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_entry_t;

    digest_entry_t digest_q[$];
    logic [63:0] hash_state [8];
    logic [63:0] msg_block [16];
    logic [63:0] msg_len;

    function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic compress_block();
        logic [63:0] v [8];
        logic [63:0] w [16];
        logic [63:0] t1;
        logic [63:0] t2;
        logic [63:0] a;
        logic [63:0] b;
        for (int i = 0; i < 8; i++)
            v[i] = hash_state[i];
        for (int i = 0; i < 16; i++)
            w[i] = msg_block[i];
        for (int t = 0; t < 80; t++)
        begin
            if (t >= 16)
            begin
                a = w[(t - 2) & 15];
                b = w[(t - 15) & 15];
                w[t & 15] = (ror64(a, 19) ^ ror64(a, 61) ^ (a >> 6)) + w[(t - 7) & 15]
                    + (ror64(b, 1) ^ ror64(b, 8) ^ (b >> 7)) + w[t & 15];
            end
            t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
                + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + KTAB[t] + w[t & 15];
            t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
                + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += v[i];
    endtask

    task automatic insert_byte(input int pos, input logic [7:0] val);
        int lane;
        logic [63:0] wd;
        lane = pos & 7;
        wd = msg_block[(pos >> 3) & 15];
        for (int j = 0; j < 8; j++)
        begin
            if (j == lane)
                wd[63 - 8*j -: 8] = val;
            else if (j > lane)
                wd[63 - 8*j -: 8] = 8'h00;
        end
        msg_block[(pos >> 3) & 15] = wd;
    endtask

    task automatic absorb_item(input logic [7:0] db, input logic bp, input logic eom);
        int pos;
        int used;
        digest_entry_t e;
        if (bp)
        begin
            pos = int'(msg_len[6:0]);
            insert_byte(pos, db);
            msg_len++;
            if (pos == int'(BLOCK_LAST_POS))
                compress_block();
        end
        if (eom)
        begin
            used = int'(msg_len[6:0]);
            insert_byte(used, PAD_BYTE);
            for (int i = (used >> 3) + 1; i < 16; i++)
                msg_block[i] = '0;
            if (used >= int'(PAD_SPLIT_POS))
            begin
                compress_block();
                for (int i = 0; i < 16; i++)
                    msg_block[i] = '0;
            end
            msg_block[14] = {61'd0, msg_len[63:61]};
            msg_block[15] = msg_len << 3;
            compress_block();
            for (int k = 0; k < 8; k++)
            begin
                e.word = hash_state[k];
                e.idx = 3'(k);
                e.last = (k == 7);
                digest_q.push_back(e);
            end
            for (int i = 0; i < 8; i++)
                hash_state[i] = IV[i];
            msg_len = '0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        msg_len = '0;
        for (int i = 0; i < 8; i++)
            hash_state[i] = IV[i];
        for (int i = 0; i < 16; i++)
            msg_block[i] = '0;
    end

    assign words_pending = digest_q.size();

    always @(posedge clk)
    begin
        digest_entry_t exp_e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (digest_q.size() == 0)
                    report_mismatch($sformatf("unexpected word %h", digest_word));
                else
                begin
                    exp_e = digest_q.pop_front();
                    if (digest_word !== exp_e.word)
                        report_mismatch($sformatf("digest_word %h exp %h", digest_word,
                            exp_e.word));
                    if (word_index !== exp_e.idx)
                        report_mismatch($sformatf("word_index %0d exp %0d", word_index,
                            exp_e.idx));
                    if (last_word !== exp_e.last)
                        report_mismatch($sformatf("last_word %b exp %b", last_word,
                            exp_e.last));
                end
            end
            if (in_valid && !in_stall)
                absorb_item(data_byte, byte_present, end_of_message);
        end
    end
endmodule

### tb/sv/sha512_stream_hasher_tb.sv
// testbench top for the sha-512 stream hasher: stimulus, idling and verdict
`timescale 1ns / 1ps
module sha512_stream_hasher_tb;
    localparam int IDLE_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        end_of_message;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    int          fail_count;
    int          words_pending;
    int          idle_cycles;
    bit          calm_phase;

    sha512_stream_hasher i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .byte_present(byte_present),
        .end_of_message(end_of_message), .out_valid(out_valid), .out_stall(out_stall),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
    );

    sha512_stream_hasher_checker i_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .byte_present(byte_present),
        .end_of_message(end_of_message), .out_valid(out_valid), .out_stall(out_stall),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word),
        .fail_count(fail_count), .words_pending(words_pending)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
        out_stall <= !calm_phase && ($urandom_range(99) < 17);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("sha512_stream_hasher_tb failed");
            $finish;
        end
    end

    // one item, with random sender gaps before it outside the calm phase
    task automatic send_item(input logic [7:0] db, input logic bp, input logic eom);
        while (!calm_phase && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= db;
        byte_present <= bp;
        end_of_message <= eom;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_message(input int nbytes, input bit noisy);
        for (int i = 0; i < nbytes; i++)
        begin
            if (noisy && $urandom_range(9) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, (i == nbytes - 1));
        end
        if (nbytes == 0)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    initial
    begin
        int sent;
        int len;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        byte_present = 1'b0;
        end_of_message = 1'b0;
        out_stall = 1'b0;
        idle_cycles = 0;
        calm_phase = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: empty message, extremes, byte with end, end without byte
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hAA, 1'b1, 1'b0);
        send_item(8'h55, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h3C, 1'b0, 1'b1);
        send_item(8'h80, 1'b1, 1'b1);
        in_valid <= 1'b0;
        while (words_pending != 0)
            @(posedge clk);
        // random: short lengths and lengths around the padding split and block boundary
        sent = 0;
        while (sent < 280)
        begin
            case ($urandom_range(5))
                0: len = $urandom_range(1, 8);
                1: len = $urandom_range(110, 113);
                2: len = $urandom_range(126, 129);
                3: len = $urandom_range(0, 40);
                default: len = $urandom_range(0, 20);
            endcase
            calm_phase = ($urandom_range(7) == 0);
            send_message(len, 1'b1);
            sent += len + 1;
            if ($urandom_range(3) == 0)
            begin
                in_valid <= 1'b0;
                while (words_pending != 0)
                    @(posedge clk);
            end
        end
        calm_phase = 1'b0;
        in_valid <= 1'b0;
        while (words_pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("sha512_stream_hasher_tb passed");
        else
            $display("sha512_stream_hasher_tb failed");
        $finish;
    end
endmodule
